// ===== hw/rtl/tcgr_pkg.sv =====
// shared types and constants of the text console glyph renderer
package tcgr_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 30;
   localparam int FONT_BYTES = 2048;

   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int ADDR_W  = 11;
   localparam int COLOR_W = 6;

   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   localparam logic [1:0] FUNC_PRINT     = 2'd0;
   localparam logic [1:0] FUNC_SET_CURSOR = 2'd1;
   localparam logic [1:0] FUNC_LOAD_FONT = 2'd2;

   localparam logic [7:0] CODE_NULL      = 8'd0;
   localparam logic [7:0] CODE_BACKSPACE = 8'd8;
   localparam logic [7:0] CODE_LINE_FEED = 8'd10;
   localparam logic [7:0] CODE_RETURN    = 8'd13;
   localparam logic [7:0] CODE_SPACE     = 8'd32;

   localparam logic [0:0] CSR_FG_COLOR = 1'd0;
   localparam logic [0:0] CSR_BG_COLOR = 1'd1;

   localparam logic [COLOR_W-1:0] FG_RESET = 6'h3F;
   localparam logic [COLOR_W-1:0] BG_RESET = 6'h00;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_PIXEL
   } state_type;

   typedef struct packed {
      logic accept;
      logic fetch;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic draw_needed;
      logic slot_free;
      logic last_pix;
   } status_type;

endpackage

// ===== hw/rtl/tcgr_ctrl.sv =====
// controller state machine of the glyph renderer
module tcgr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tcgr_pkg::status_type status,
   output tcgr_pkg::cmd_type    cmd
);
   import tcgr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.draw_needed) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_PIXEL;
         end
         ST_PIXEL: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               if (status.last_pix) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/tcgr_datapath.sv =====
// cursor, font memory, pixel counter and output register
module tcgr_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [0:0]           csr_index,
   input  logic [5:0]           csr_wdata,
   input  logic [1:0]           req_func,
   input  logic [7:0]           req_char_code,
   input  logic [7:0]           req_col_request,
   input  logic [7:0]           req_row_request,
   input  logic [10:0]          req_font_addr,
   input  logic [7:0]           req_font_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [9:0]           rsp_pixel_x,
   output logic [7:0]           rsp_pixel_y,
   output logic [5:0]           rsp_pixel_color,
   output logic                 rsp_last_pixel,
   input  tcgr_pkg::cmd_type    cmd,
   output tcgr_pkg::status_type status
);
   import tcgr_pkg::*;

   logic [COLOR_W-1:0] fg_ff, bg_ff;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   draw_col_ff, draw_col_in;
   logic [ROW_W-1:0]   draw_row_ff, draw_row_in;
   logic [7:0]         glyph_ff, glyph_in;
   logic               draw_needed;

   logic [7:0]         font_mem [FONT_BYTES];
   logic [7:0]         font_rd_ff;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;

   logic [5:0]         pix_ff, pix_in;
   logic [7:0]         row_bits_ff, row_bits_in;
   logic [7:0]         cur_bits;
   logic [2:0]         bit_idx, line_idx;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [9:0]         px_ff;
   logic [7:0]         py_ff;
   logic [5:0]         pc_ff;
   logic               pl_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= FG_RESET;
         bg_ff <= BG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FG_COLOR: fg_ff <= csr_wdata;
            CSR_BG_COLOR: bg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request decode and cursor update
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      draw_col_in = draw_col_ff;
      draw_row_in = draw_row_ff;
      glyph_in    = glyph_ff;
      draw_needed = 1'b0;
      unique case (req_func)
         FUNC_SET_CURSOR: begin
            col_in = (req_col_request >= 8'(COLUMNS)) ? LAST_COL : req_col_request[COL_W-1:0];
            row_in = (req_row_request >= 8'(ROWS)) ? LAST_ROW : req_row_request[ROW_W-1:0];
         end
         FUNC_PRINT: begin
            case (req_char_code)
               CODE_NULL: ;
               CODE_RETURN: col_in = '0;
               CODE_LINE_FEED: begin
                  if (row_ff < LAST_ROW) begin
                     col_in = '0;
                     row_in = row_ff + ROW_W'(1);
                  end
               end
               CODE_BACKSPACE: begin
                  if (col_ff != '0) begin
                     col_in      = col_ff - COL_W'(1);
                     draw_col_in = col_ff - COL_W'(1);
                     draw_row_in = row_ff;
                     glyph_in    = CODE_SPACE - 8'd1;
                     draw_needed = 1'b1;
                  end
               end
               default: begin
                  draw_col_in = col_ff;
                  draw_row_in = row_ff;
                  glyph_in    = req_char_code - 8'd1;
                  draw_needed = 1'b1;
                  if (col_ff < LAST_COL) begin
                     col_in = col_ff + COL_W'(1);
                  end else if (row_ff < LAST_ROW) begin
                     col_in = '0;
                     row_in = row_ff + ROW_W'(1);
                  end
               end
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         draw_col_ff <= draw_col_in;
         draw_row_ff <= draw_row_in;
         glyph_ff    <= glyph_in;
      end
   end

   // pixel walk: row-major, next font row prefetched at each row start
   assign bit_idx  = pix_ff[2:0];
   assign line_idx = pix_ff[5:3];
   assign cur_bits = (bit_idx == 3'd0) ? font_rd_ff : row_bits_ff;
   assign row_bits_in = {cur_bits[6:0], 1'b0};
   assign rd_en    = cmd.fetch || (cmd.emit && bit_idx == 3'd0);
   assign rd_addr  = cmd.fetch ? {glyph_ff, 3'd0} : {glyph_ff, line_idx + 3'd1};
   assign pix_in   = cmd.fetch ? 6'd0 : pix_ff + 6'd1;

   always_ff @(posedge clock) begin
      if (cmd.accept && req_func == FUNC_LOAD_FONT) begin
         font_mem[req_font_addr] <= req_font_byte;
      end
      if (rd_en) begin
         font_rd_ff <= font_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff <= '0;
      end else if (cmd.fetch || cmd.emit) begin
         pix_ff <= pix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         row_bits_ff <= row_bits_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         px_ff <= {draw_col_ff, bit_idx};
         py_ff <= {draw_row_ff, line_idx};
         pc_ff <= cur_bits[7] ? fg_ff : bg_ff;
         pl_ff <= (pix_ff == 6'd63);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = px_ff;
   assign rsp_pixel_y     = py_ff;
   assign rsp_pixel_color = pc_ff;
   assign rsp_last_pixel  = pl_ff;

   assign status.draw_needed = draw_needed;
   assign status.slot_free   = !rsp_valid_ff || rsp_ready;
   assign status.last_pix    = (pix_ff == 6'd63);

endmodule

// ===== hw/rtl/text_console_glyph_renderer_unit.sv =====
// top level of the text console glyph renderer
//
// text console on an 80 x 30 grid of 8x8 cells with no scrolling. each request
// is one of: print a character, set the cursor (clamped to the grid), or load
// one byte of the 2048-byte font memory. printable codes and a backspace away
// from column 0 draw a glyph as 64 pixel writes in row-major order, glyph c taken
// from font bytes 8*(c-1) on; the last write carries last_pixel. return, line
// feed, null, cursor and font requests give no pixels. a drawn glyph is accepted,
// then one font read primes the registered memory output, then one pixel per cycle
// goes out through the single output register while rsp_ready lets it; a waiting
// pixel holds while rsp_ready is low. the font memory is read once per glyph row
// while the previous row shifts out. requests are taken one at a time; the next
// one is taken while the last pixel still sits in the output register. fg and bg
// colors are to be written by the user through the csr port only while the block
// is idle; the block itself does not enforce this. font bytes read before being
// loaded give undefined colors. reset does not clear the font.
module text_console_glyph_renderer_unit (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [5:0]  csr_wdata,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_col_request,
   input  logic [7:0]  req_row_request,
   input  logic [10:0] req_font_addr,
   input  logic [7:0]  req_font_byte,
   // pixel channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_pixel_x,
   output logic [7:0]  rsp_pixel_y,
   output logic [5:0]  rsp_pixel_color,
   output logic        rsp_last_pixel
);
   import tcgr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing of accept, font prime and pixel emission
   tcgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // cursor, colors, font memory and pixel output register
   tcgr_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_func        (req_func),
      .req_char_code   (req_char_code),
      .req_col_request (req_col_request),
      .req_row_request (req_row_request),
      .req_font_addr   (req_font_addr),
      .req_font_byte   (req_font_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_pixel  (rsp_last_pixel),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

// ===== hw/rtl/tcgr_checker.sv =====
// port-level checks of the glyph renderer and their binding
module tcgr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [9:0]  rsp_pixel_x,
   input logic [7:0]  rsp_pixel_y,
   input logic [5:0]  rsp_pixel_color,
   input logic        rsp_last_pixel
);

   // a stalled pixel holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x)
         && $stable(rsp_pixel_y) && $stable(rsp_pixel_color) && $stable(rsp_last_pixel))
      else $error("pixel changed while stalled");

   // last pixel is the bottom-right pixel of its cell
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_pixel |-> rsp_pixel_x[2:0] == 3'd7 && rsp_pixel_y[2:0] == 3'd7)
      else $error("last pixel not at cell corner");

   // pixels of a glyph follow without gaps in the same cell
   a_glyph_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_pixel |=> rsp_valid
         && rsp_pixel_x[9:3] == $past(rsp_pixel_x[9:3])
         && rsp_pixel_y[7:3] == $past(rsp_pixel_y[7:3]))
      else $error("glyph burst broken");

   // no new request while a glyph is still being drawn
   a_busy_drawing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_pixel |-> !req_ready)
      else $error("request taken mid glyph");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("pixel valid after reset");

endmodule

bind text_console_glyph_renderer_unit tcgr_checker u_tcgr_checker (.*);

// ===== tb/tb.sv =====
// self-checking testbench of the text console glyph renderer
`timescale 1ns / 100ps

module tb;
   import tcgr_pkg::*;

   // func value that the console ignores
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam int RESET_CYCLES    = 4;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 42;
   localparam int IDLE_SETTLE     = 8;
   localparam int TAIL_CYCLES     = 70;    // one whole glyph and then some
   localparam int LONG_HOLD       = 600;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int REPORT_LIMIT    = 10;

   // how the pixels of a request are worked out
   typedef enum logic [1:0] {
      PIX_FROM_MODEL,   // running console state
      PIX_NONE,         // request draws nothing
      PIX_AT_CELL       // glyph at the cell typed in the row
   } pix_check_type;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_COIN,
      RX_THREE_OF_FOUR,
      RX_RARE_STALL
   } rx_mode_type;

   typedef struct packed {
      logic [1:0]    func;
      logic [7:0]    char_code;
      logic [7:0]    col_request;
      logic [7:0]    row_request;
      logic [10:0]   font_addr;
      logic [7:0]    font_byte;
      pix_check_type check;
      logic [6:0]    cell_col;
      logic [4:0]    cell_row;
   } console_req_type;

   typedef struct packed {
      logic [9:0] x;
      logic [7:0] y;
      logic [5:0] color;
      logic       last;
   } pixel_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // block ports, the driven inputs all known from time zero
   logic        csr_we          = 1'b0;
   logic [0:0]  csr_index       = CSR_FG_COLOR;
   logic [5:0]  csr_wdata       = 6'd0;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func        = FUNC_PRINT;
   logic [7:0]  req_char_code   = 8'd0;
   logic [7:0]  req_col_request = 8'd0;
   logic [7:0]  req_row_request = 8'd0;
   logic [10:0] req_font_addr   = 11'd0;
   logic [7:0]  req_font_byte   = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [9:0]  rsp_pixel_x;
   logic [7:0]  rsp_pixel_y;
   logic [5:0]  rsp_pixel_color;
   logic        rsp_last_pixel;

   text_console_glyph_renderer_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_char_code   (req_char_code),
      .req_col_request (req_col_request),
      .req_row_request (req_row_request),
      .req_font_addr   (req_font_addr),
      .req_font_byte   (req_font_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_pixel  (rsp_last_pixel)
   );

   // ---------------------------------------------------------------------
   // console state as the testbench sees it, updated at each accepted request
   // ---------------------------------------------------------------------
   logic [6:0] cur_col;
   logic [4:0] cur_row;
   logic [5:0] fg_model;
   logic [5:0] bg_model;
   logic [7:0] font_copy [FONT_BYTES];

   pixel_type glyph_pixels [$];   // pixels of the request being worked out
   pixel_type pixels_due [$];     // pixels the console still owes, oldest first

   // requests waiting to go out, and font bytes already scheduled for loading
   console_req_type queued_requests [$];
   logic            font_scheduled [FONT_BYTES];

   int mismatch_count = 0;
   int long_hold_asked = 0;

   // one glyph, rows top down, leftmost pixel from the msb
   function automatic void paint_cell(input logic [6:0] col, input logic [4:0] row,
                                      input logic [7:0] code);
      logic [10:0] base;
      logic [7:0]  line;
      pixel_type   p;
      base = {code - 8'd1, 3'b000};
      for (int gy = 0; gy < 8; gy++) begin
         line = font_copy[base + 11'(gy)];
         for (int gx = 0; gx < 8; gx++) begin
            p.x     = {col, 3'(gx)};
            p.y     = {row, 3'(gy)};
            p.color = line[7 - gx] ? fg_model : bg_model;
            p.last  = (gy == 7) && (gx == 7);
            glyph_pixels.push_back(p);
         end
      end
   endfunction

   // cursor and font update of one request, glyph pixels into glyph_pixels
   function automatic void console_step(input console_req_type r);
      logic [6:0] at_col;
      logic [4:0] at_row;
      case (r.func)
         FUNC_SET_CURSOR: begin
            cur_col = (r.col_request >= COLUMNS) ? LAST_COL : r.col_request[6:0];
            cur_row = (r.row_request >= ROWS) ? LAST_ROW : r.row_request[4:0];
         end
         FUNC_LOAD_FONT: begin
            font_copy[r.font_addr] = r.font_byte;
         end
         FUNC_PRINT: begin
            if (r.char_code == CODE_RETURN) begin
               cur_col = '0;
            end else if (r.char_code == CODE_LINE_FEED) begin
               // no scrolling: on the last row a line feed is dropped
               if (cur_row < LAST_ROW) begin
                  cur_col = '0;
                  cur_row = cur_row + 5'd1;
               end
            end else if (r.char_code == CODE_BACKSPACE) begin
               if (cur_col != '0) begin
                  cur_col = cur_col - 7'd1;
                  paint_cell(cur_col, cur_row, CODE_SPACE);
               end
            end else if (r.char_code != CODE_NULL) begin
               at_col = cur_col;
               at_row = cur_row;
               // advance, wrap, and park on the bottom-right cell
               if (cur_col < LAST_COL) begin
                  cur_col = cur_col + 7'd1;
               end else if (cur_row < LAST_ROW) begin
                  cur_col = '0;
                  cur_row = cur_row + 5'd1;
               end
               paint_cell(at_col, at_row, r.char_code);
            end
         end
         default: ;
      endcase
   endfunction

   // predict the pixels of an accepted request and queue them
   function automatic void render_request(input console_req_type r);
      glyph_pixels.delete();
      console_step(r);
      case (r.check)
         PIX_NONE: glyph_pixels.delete();
         PIX_AT_CELL: begin
            // typed cell: a backspace blanks with the space glyph
            glyph_pixels.delete();
            paint_cell(r.cell_col, r.cell_row,
                       (r.char_code == CODE_BACKSPACE) ? CODE_SPACE : r.char_code);
         end
         default: ;
      endcase
      foreach (glyph_pixels[k]) pixels_due.push_back(glyph_pixels[k]);
   endfunction

   // ---------------------------------------------------------------------
   // stimulus generation
   // ---------------------------------------------------------------------
   function automatic logic [7:0] font_pattern();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // printable codes whose glyphs the directed part already loads,
   // both ends of the code range among them
   function automatic logic [7:0] pool_code();
      case ($urandom_range(0, 9))
         0:       return 8'd1;
         1:       return CODE_SPACE;
         2:       return 8'd65;
         3:       return 8'd66;
         4:       return 8'd67;
         5:       return 8'd90;
         6:       return 8'd127;
         7:       return 8'd128;
         8:       return 8'd200;
         default: return 8'd255;
      endcase
   endfunction

   function automatic console_req_type random_fields();
      console_req_type r;
      r.func        = 2'($urandom);
      r.char_code   = 8'($urandom);
      r.col_request = 8'($urandom);
      r.row_request = 8'($urandom);
      r.font_addr   = 11'($urandom);
      r.font_byte   = font_pattern();
      r.check       = PIX_FROM_MODEL;
      r.cell_col    = '0;
      r.cell_row    = '0;
      return r;
   endfunction

   // make sure every font byte a print may read is loaded before it
   function automatic void load_glyph_for(input logic [7:0] code);
      logic [7:0]      glyph;
      logic [10:0]     addr;
      console_req_type ld;
      if (code == CODE_NULL || code == CODE_LINE_FEED || code == CODE_RETURN) return;
      glyph = (code == CODE_BACKSPACE) ? CODE_SPACE : code;
      for (int k = 0; k < 8; k++) begin
         addr = {glyph - 8'd1, 3'b000} + 11'(k);
         if (!font_scheduled[addr]) begin
            ld           = random_fields();
            ld.func      = FUNC_LOAD_FONT;
            ld.font_addr = addr;
            ld.check     = PIX_NONE;
            font_scheduled[addr] = 1'b1;
            queued_requests.push_back(ld);
         end
      end
   endfunction

   function automatic void queue_request(input console_req_type r);
      if (r.func == FUNC_PRINT) load_glyph_for(r.char_code);
      if (r.func == FUNC_LOAD_FONT) font_scheduled[r.font_addr] = 1'b1;
      queued_requests.push_back(r);
   endfunction

   // mostly printing, with enough cursor moves to reach wraps and the last row
   function automatic void queue_random_request();
      console_req_type r;
      int pick;
      r    = random_fields();
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         r.func      = FUNC_PRINT;
         r.char_code = pool_code();
      end else if (pick < 66) begin
         r.func = FUNC_PRINT;
         case ($urandom_range(0, 3))
            0:       r.char_code = CODE_BACKSPACE;
            1:       r.char_code = CODE_LINE_FEED;
            2:       r.char_code = CODE_RETURN;
            default: r.char_code = CODE_NULL;
         endcase
      end else if (pick < 78) begin
         r.func = FUNC_SET_CURSOR;
         case ($urandom_range(0, 2))
            0: ;   // anywhere in the 8-bit range
            1: begin
               r.col_request = 8'($urandom_range(0, COLUMNS - 1));
               r.row_request = 8'($urandom_range(0, ROWS - 1));
            end
            default: begin
               // around the bottom-right corner
               r.col_request = 8'($urandom_range(COLUMNS - 4, COLUMNS + 2));
               r.row_request = 8'($urandom_range(ROWS - 3, ROWS + 1));
            end
         endcase
      end else if (pick < 95) begin
         r.func = FUNC_LOAD_FONT;
      end else begin
         r.func = FUNC_UNUSED;
      end
      queue_request(r);
   endfunction

   // directed requests; typed cells where the cursor is plain to see
   console_req_type directed_rows [0:24] = '{
      // func           code            col      row      addr      font   check        cell
      '{FUNC_PRINT,      8'd65,          8'd0,    8'd0,    11'd0,    8'h00, PIX_AT_CELL, 7'd0,  5'd0},
      '{FUNC_PRINT,      CODE_BACKSPACE, 8'd0,    8'd0,    11'd0,    8'h00, PIX_AT_CELL, 7'd0,  5'd0},
      '{FUNC_PRINT,      CODE_BACKSPACE, 8'd0,    8'd0,    11'd0,    8'h00, PIX_NONE,    7'd0,  5'd0},
      '{FUNC_PRINT,      CODE_NULL,      8'd0,    8'd0,    11'd0,    8'h00, PIX_NONE,    7'd0,  5'd0},
      '{FUNC_UNUSED,     8'd65,          8'd3,    8'd3,    11'd5,    8'hA5, PIX_NONE,    7'd0,  5'd0},
      '{FUNC_SET_CURSOR, 8'd0,           8'd255,  8'd255,  11'd0,    8'h00, PIX_NONE,    7'd0,  5'd0},
      '{FUNC_PRINT,      8'd255,         8'd0,    8'd0,    11'd0,    8'h00, PIX_AT_CELL, 7'd79, 5'd29},
      '{FUNC_PRINT,      8'd1,           8'd0,    8'd0,    11'd0,    8'h00, PIX_AT_CELL, 7'd79, 5'd29},
      '{FUNC_PRINT,      CODE_LINE_FEED, 8'd0,    8'd0,    11'd0,    8'h00, PIX_NONE,    7'd0,  5'd0},
      '{FUNC_PRINT,      CODE_RETURN,    8'd0,    8'd0,    11'd0,    8'h00, PIX_NONE,    7'd0,  5'd0},
      '{FUNC_PRINT,      8'd128,         8'd0,    8'd0,    11'd0,    8'h00, PIX_AT_CELL, 7'd0,  5'd29},
      '{FUNC_SET_CURSOR, 8'd0,           8'd79,   8'd0,    11'd0,    8'h00, PIX_NONE,    7'd0,  5'd0},
      '{FUNC_PRINT,      8'd90,          8'd0,    8'd0,    11'd0,    8'h00, PIX_AT_CELL, 7'd79, 5'd0},
      '{FUNC_PRINT,      8'd127,         8'd0,    8'd0,    11'd0,    8'h00, PIX_AT_CELL, 7'd0,  5'd1},
      '{FUNC_PRINT,      CODE_LINE_FEED, 8'd0,    8'd0,    11'd0,    8'h00, PIX_NONE,    7'd0,  5'd0},
      '{FUNC_PRINT,      8'd66,          8'd0,    8'd0,    11'd0,    8'h00, PIX_AT_CELL, 7'd0,  5'd2},
      '{FUNC_SET_CURSOR, 8'd0,           8'd80,   8'd30,   11'd0,    8'h00, PIX_NONE,    7'd0,  5'd0},
      '{FUNC_PRINT,      CODE_BACKSPACE, 8'd0,    8'd0,    11'd0,    8'h00, PIX_AT_CELL, 7'd78, 5'd29},
      '{FUNC_SET_CURSOR, 8'd0,           8'd5,    8'd3,    11'd0,    8'h00, PIX_NONE,    7'd0,  5'd0},
      '{FUNC_PRINT,      8'd67,          8'd0,    8'd0,    11'd0,    8'h00, PIX_AT_CELL, 7'd5,  5'd3},
      '{FUNC_PRINT,      CODE_RETURN,    8'd0,    8'd0,    11'd0,    8'h00, PIX_NONE,    7'd0,  5'd0},
      '{FUNC_LOAD_FONT,  8'd0,           8'd0,    8'd0,    11'd2047, 8'hFF, PIX_NONE,    7'd0,  5'd0},
      '{FUNC_LOAD_FONT,  8'd0,           8'd0,    8'd0,    11'd0,    8'h00, PIX_NONE,    7'd0,  5'd0},
      '{FUNC_PRINT,      8'd1,           8'd0,    8'd0,    11'd0,    8'h00, PIX_FROM_MODEL, 7'd0, 5'd0},
      '{FUNC_PRINT,      8'd200,         8'd0,    8'd0,    11'd0,    8'h00, PIX_FROM_MODEL, 7'd0, 5'd0}
   };

   // ---------------------------------------------------------------------
   // request driver: bursts of random length with random gaps between them
   // ---------------------------------------------------------------------
   console_req_type on_bus;
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         // request taken at this edge: predict its pixels
         if (req_valid && req_ready) render_request(on_bus);

         if (req_valid && !req_ready) begin
            // hold valid and payload until taken
         end else if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (queued_requests.size() != 0) begin
            on_bus = queued_requests.pop_front();
            req_func        <= on_bus.func;
            req_char_code   <= on_bus.char_code;
            req_col_request <= on_bus.col_request;
            req_row_request <= on_bus.row_request;
            req_font_addr   <= on_bus.font_addr;
            req_font_byte   <= on_bus.font_byte;
            req_valid       <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 16);
               // a third of the bursts run straight into the next one
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // pixel receiver: stall pattern switched among four random modes,
   // plus one long hold-off on request from the run sequence
   // ---------------------------------------------------------------------
   rx_mode_type rx_mode = RX_ALWAYS;
   int          rx_mode_left = 0;
   logic [1:0]  rx_tick = 2'd0;
   int          long_hold_served = 0;
   int          hold_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (long_hold_served != long_hold_asked) begin
            long_hold_served = long_hold_asked;
            hold_left        = LONG_HOLD;
         end
         if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_type'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(8, 64);
         end else begin
            rx_mode_left--;
         end
         rx_tick = rx_tick + 2'd1;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_ALWAYS:        rsp_ready <= 1'b1;
               RX_COIN:          rsp_ready <= 1'($urandom);
               RX_THREE_OF_FOUR: rsp_ready <= (rx_tick != 2'd3);
               default:          rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // pixel checker: each pixel against the oldest one still due
   // ---------------------------------------------------------------------
   task automatic report_pixel(input string what, input pixel_type want,
                               input pixel_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t %s: want x=%0d y=%0d color=%0d last=%0d, %s",
                  $realtime, what, want.x, want.y, want.color, want.last,
                  $sformatf("got x=%0d y=%0d color=%0d last=%0d",
                            got.x, got.y, got.color, got.last));
   endtask

   always @(posedge clock) begin : pixel_check
      pixel_type got;
      pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_pixel_x, rsp_pixel_y, rsp_pixel_color, rsp_last_pixel};
         if (pixels_due.size() == 0) begin
            report_pixel("pixel with none due", '0, got);
         end else begin
            want = pixels_due.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
                got.last !== want.last)
               report_pixel("pixel mismatch", want, got);
         end
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: cycles without any handshake on either channel
   // ---------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("%0t watchdog: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // run sequence
   // ---------------------------------------------------------------------

   // all requests taken, all pixels seen, then a short settle
   task automatic wait_drained();
      do @(negedge clock);
      while (queued_requests.size() != 0 || req_valid || pixels_due.size() != 0);
      repeat (IDLE_SETTLE) @(negedge clock);
   endtask

   // color writes, only while the console is idle
   task automatic write_colors(input logic [5:0] fg, input logic [5:0] bg);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_FG_COLOR;
      csr_wdata <= fg;
      @(posedge clock);
      csr_index <= CSR_BG_COLOR;
      csr_wdata <= bg;
      @(posedge clock);
      csr_we   <= 1'b0;
      fg_model = fg;
      bg_model = bg;
   endtask

   initial begin : run
      logic [5:0] fg_set [PHASES];
      logic [5:0] bg_set [PHASES];

      cur_col  = '0;
      cur_row  = '0;
      fg_model = FG_RESET;
      bg_model = BG_RESET;
      foreach (font_scheduled[k]) font_scheduled[k] = 1'b0;

      // extremes first, then mixed and random colors
      fg_set = '{6'd0,  6'd63, 6'd0, 6'($urandom), 6'd21, 6'($urandom)};
      bg_set = '{6'd63, 6'd63, 6'd0, 6'($urandom), 6'd42, 6'($urandom)};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed requests with the reset colors
      foreach (directed_rows[k]) queue_request(directed_rows[k]);
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         write_colors(fg_set[phase], bg_set[phase]);
         // one long pixel hold-off so the console backs up into the request side
         if (phase == 2) long_hold_asked++;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) queue_random_request();
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pixels_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d pixel mismatches, %0d pixels missing", mismatch_count,
                  pixels_due.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== text_console_glyph_renderer_unit.f =====
hw/rtl/tcgr_pkg.sv
hw/rtl/tcgr_ctrl.sv
hw/rtl/tcgr_datapath.sv
hw/rtl/text_console_glyph_renderer_unit.sv
hw/rtl/tcgr_checker.sv
tb/tb.sv
